// File: sv/afd_pkg.sv
// Package for the API frame deframer: status codes, framing constants and
// register map. No dependencies.
package afd_pkg;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD     = 2'd2,
        ST_TOOLONG = 2'd3
    } status_t;

    localparam logic [7:0]  START_BYTE      = 8'h7E;
    localparam logic [7:0]  SUM_BASE        = 8'hFF;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd255;

    localparam int          ADDR_W          = 3;
    localparam logic [0:0]  REG_MAX_LENGTH  = 1'b0;

endpackage

// File: sv/afd_apb_regs.sv
// APB-style register block of the API frame deframer: holds max_length.
// Depends on afd_pkg.
module afd_apb_regs
    import afd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [15:0]       max_length
);

    logic [15:0] max_length_reg;
    logic [15:0] max_length_next;
    logic        wr_en;
    logic [0:0]  reg_index;

    assign reg_index = paddr[ADDR_W-1:ADDR_W-1];
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_MAX_LENGTH);
    assign pready    = 1'b1;
    assign max_length = max_length_reg;

    always_comb
    begin
        max_length_next = max_length_reg;
        if (wr_en)
        begin
            max_length_next = pwdata[15:0];
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MAX_LENGTH: prdata = {16'd0, max_length_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

endmodule

// File: sv/afd_parser.sv
// Frame parser of the API frame deframer: input register, framing state and
// result register. Depends on afd_pkg.
module afd_parser
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] max_length,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_first,
    output logic        is_last,
    output status_t     status,
    output logic [7:0]  computed_sum
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CSUM   = 3'd4
    } phase_t;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg,        phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_seen_reg,   bytes_seen_next;
    logic [7:0]  running_sum_reg,  running_sum_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        is_first_reg;
    logic        is_last_reg;
    status_t     status_reg;
    logic [7:0]  computed_sum_reg;

    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_first;
    logic        res_last;
    status_t     res_status;
    logic [7:0]  res_sum;

    logic        advance;
    logic [15:0] len_full;
    logic [15:0] seen_inc;
    logic [7:0]  sum_inc;
    logic [7:0]  expect_sum;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    assign len_full   = {frame_length_reg[15:8], in_byte_reg};
    assign seen_inc   = bytes_seen_reg + 16'd1;
    assign sum_inc    = running_sum_reg + in_byte_reg;
    assign expect_sum = SUM_BASE - running_sum_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_sum_next  = running_sum_reg;
        res_valid         = 1'b0;
        res_byte          = 8'd0;
        res_first         = 1'b0;
        res_last          = 1'b0;
        res_status        = ST_DATA;
        res_sum           = 8'd0;
        case (phase_reg)
            PH_LEN_HI:
            begin
                frame_length_next = {in_byte_reg, 8'h00};
                phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length_next = len_full;
                bytes_seen_next   = 16'd0;
                running_sum_next  = 8'd0;
                if (len_full > max_length)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res_last   = 1'b1;
                    res_status = ST_TOOLONG;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = PH_CSUM;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                running_sum_next = sum_inc;
                bytes_seen_next  = seen_inc;
                if (seen_inc >= frame_length_reg)
                begin
                    phase_next = PH_CSUM;
                end
                res_valid = 1'b1;
                res_byte  = in_byte_reg;
                res_first = (bytes_seen_reg == 16'd0);
            end
            PH_CSUM:
            begin
                phase_next = PH_HUNT;
                res_valid  = 1'b1;
                res_byte   = in_byte_reg;
                res_last   = 1'b1;
                res_status = (in_byte_reg == expect_sum) ? ST_OK : ST_BAD;
                res_sum    = expect_sum;
            end
            default:
            begin
                phase_next = (in_byte_reg == START_BYTE) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_HUNT;
            frame_length_reg <= 16'd0;
            bytes_seen_reg   <= 16'd0;
            running_sum_reg  <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && res_valid;
                if (in_valid_reg)
                begin
                    phase_reg        <= phase_next;
                    frame_length_reg <= frame_length_next;
                    bytes_seen_reg   <= bytes_seen_next;
                    running_sum_reg  <= running_sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && in_valid_reg && res_valid)
        begin
            out_byte_reg     <= res_byte;
            is_first_reg     <= res_first;
            is_last_reg      <= res_last;
            status_reg       <= res_status;
            computed_sum_reg <= res_sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_first     = is_first_reg;
    assign is_last      = is_last_reg;
    assign status       = status_reg;
    assign computed_sum = computed_sum_reg;

endmodule

// File: sv/api_frame_deframer.sv
// API frame deframer, top level: register block and frame parser.
// Depends on afd_pkg, afd_apb_regs, afd_parser.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one serial byte per
//   transfer. Bytes are dropped until a 0x7E start byte, then a 16-bit
//   big-endian length, the frame data and a checksum byte follow.
//   Output channel (out_valid/out_ready) gives one transfer per data byte
//   (is_first on the frame type) and one end transfer on the checksum byte
//   with status ok or bad and the expected sum; a length above max_length
//   gives a too-long end transfer instead and hunting restarts.
//   Throughput: one byte per cycle while the output is taken. A byte goes into
//   the input register when it is transferred and the parser logic loads its
//   result into the result register once the output can advance, which
//   raises out_valid.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; in_ready drops only while both are
//   full and the output is not taken.
//   Reset clears both pipeline registers, returns the parser to hunting and
//   sets max_length to 255. max_length lies at APB byte address 0; the user
//   must write it only while the block is idle, the block does not enforce it.
module api_frame_deframer
    import afd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              is_first,
    output logic              is_last,
    output logic [1:0]        status,
    output logic [7:0]        computed_sum
);

    logic [15:0] max_length;
    status_t     status_int;

    afd_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    afd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_length   (max_length),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_first     (is_first),
        .is_last      (is_last),
        .status       (status_int),
        .computed_sum (computed_sum)
    );

    assign status = status_int;

`ifndef ASSERT_OFF
    a_ready_drop_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled output");

    a_last_has_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_last) |-> (status_int != ST_DATA))
        else $error("end transfer with data status");

    a_first_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_first) |-> (status_int == ST_DATA && !is_last))
        else $error("frame type flag on an end transfer");

    a_ok_matches_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_int == ST_OK) |-> (out_byte == computed_sum))
        else $error("checksum ok but bytes differ");
`endif

endmodule
